>>> src/bdpa_pkg.sv
// ---------------------------------------------------------------------------
// bdpa_pkg
// Shared types and codes for the binary diff patch applier: item codes,
// record kinds, phases, status codes and the state and result records.
// ---------------------------------------------------------------------------
package bdpa_pkg;

   localparam int HDR_LEN_BYTES = 4;   // length bytes ahead of the kind byte

   // Input item codes.
   localparam logic [1:0] FUNC_DIFF     = 2'd0;
   localparam logic [1:0] FUNC_SRC      = 2'd1;
   localparam logic [1:0] FUNC_DIFF_END = 2'd2;
   localparam logic [1:0] FUNC_SRC_END  = 2'd3;

   // Stream expected next.
   localparam logic [1:0] WANT_DIFF = 2'd0;
   localparam logic [1:0] WANT_SRC  = 2'd1;
   localparam logic [1:0] WANT_NONE = 2'd2;

   // Record kinds.
   localparam logic [2:0] KIND_COPY   = 3'd0;
   localparam logic [2:0] KIND_XOR    = 3'd1;
   localparam logic [2:0] KIND_INSERT = 3'd2;
   localparam logic [2:0] KIND_VERIFY = 3'd3;
   localparam logic [2:0] KIND_FILL   = 3'd4;
   localparam logic [2:0] KIND_CHECK  = 3'd5;
   localparam logic [7:0] KIND_MAX    = 8'd5;

   // Phases of the record parser.
   localparam logic [2:0] PH_HDR   = 3'd0;
   localparam logic [2:0] PH_FINAL = 3'd1;
   localparam logic [2:0] PH_PLOAD = 3'd2;
   localparam logic [2:0] PH_FILL  = 3'd3;
   localparam logic [2:0] PH_BODY  = 3'd4;
   localparam logic [2:0] PH_STOP  = 3'd5;

   // Status codes.
   localparam logic [2:0] ST_RUNNING    = 3'd0;
   localparam logic [2:0] ST_DONE       = 3'd1;
   localparam logic [2:0] ST_EXTRA_SRC  = 3'd2;
   localparam logic [2:0] ST_MISMATCH   = 3'd3;
   localparam logic [2:0] ST_BAD_KIND   = 3'd4;
   localparam logic [2:0] ST_SRC_SHORT  = 3'd5;
   localparam logic [2:0] ST_DIFF_SHORT = 3'd6;

   typedef struct packed {
      logic [2:0]  phase;
      logic [2:0]  header_count;
      logic [31:0] remaining_length;
      logic [2:0]  record_kind;
      logic [7:0]  held_source;
      logic        have_source;
      logic [31:0] fill_pattern;
      logic [1:0]  pattern_index;
      logic [2:0]  sticky_status;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:            PH_HDR,
      header_count:     3'd0,
      remaining_length: 32'd0,
      record_kind:      KIND_COPY,
      held_source:      8'd0,
      have_source:      1'b0,
      fill_pattern:     32'd0,
      pattern_index:    2'd0,
      sticky_status:    ST_RUNNING
   };

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic [1:0] want_stream;
      logic [2:0] status;
   } result_type;

endpackage

>>> src/bdpa_step.sv
// ---------------------------------------------------------------------------
// bdpa_step
// Next-state and result logic for one input item of the patch applier.
// ---------------------------------------------------------------------------
module bdpa_step (
   input  bdpa_pkg::state_type  cur,
   input  logic                 reverse_mode,
   input  logic [1:0]           func,
   input  logic [7:0]           data_byte,
   output bdpa_pkg::state_type  nxt,
   output bdpa_pkg::result_type res
);
   import bdpa_pkg::*;

   logic [1:0]  need;
   logic [31:0] rl_dec;
   logic [7:0]  kind_adj;
   logic [7:0]  pat_byte;
   logic [1:0]  pi_inc;
   logic [31:0] len_base;
   logic        body_take;

   function automatic logic [1:0] wanted(input state_type s);
      logic [1:0] w;
      w = WANT_NONE;
      unique case (s.phase)
         PH_HDR, PH_PLOAD, PH_FILL: w = WANT_DIFF;
         PH_FINAL:                  w = WANT_SRC;
         PH_BODY: begin
            if (s.record_kind == KIND_INSERT)
               w = WANT_DIFF;
            else if (s.record_kind == KIND_XOR || s.record_kind == KIND_VERIFY)
               w = s.have_source ? WANT_DIFF : WANT_SRC;
            else
               w = WANT_SRC;
         end
         default: w = WANT_NONE;
      endcase
      return w;
   endfunction

   assign need     = wanted(cur);
   assign rl_dec   = cur.remaining_length - 32'd1;
   assign pat_byte = 8'(cur.fill_pattern >> {cur.pattern_index, 3'b000});
   assign pi_inc   = cur.pattern_index + 2'd1;
   assign len_base = (cur.header_count == 3'd0) ? 32'd0 : cur.remaining_length;
   assign body_take = (need == WANT_SRC && func == FUNC_SRC) ||
                      (need == WANT_DIFF && func == FUNC_DIFF);

   // Reverse mode swaps insert with verify and fill with check.
   always_comb begin
      kind_adj = data_byte;
      if (reverse_mode && data_byte >= 8'(KIND_INSERT) && data_byte <= KIND_MAX)
         kind_adj = data_byte ^ 8'd1;
   end

   always_comb begin
      nxt           = cur;
      res.out_valid = 1'b0;
      res.out_byte  = 8'd0;

      unique case (cur.phase)
         PH_HDR: begin
            if (func == FUNC_DIFF) begin
               if (cur.header_count < 3'(HDR_LEN_BYTES)) begin
                  nxt.remaining_length = len_base |
                     ({24'd0, data_byte} << {cur.header_count[1:0], 3'b000});
                  nxt.header_count = cur.header_count + 3'd1;
               end else begin
                  nxt.header_count = 3'd0;
                  if (kind_adj > KIND_MAX) begin
                     nxt.sticky_status = ST_BAD_KIND;
                     nxt.phase         = PH_STOP;
                  end else begin
                     nxt.record_kind   = kind_adj[2:0];
                     nxt.have_source   = 1'b0;
                     nxt.pattern_index = 2'd0;
                     if (kind_adj[2:0] >= KIND_FILL) begin
                        nxt.fill_pattern = 32'd0;
                        nxt.phase        = PH_PLOAD;
                     end else if (cur.remaining_length == 32'd0) begin
                        nxt.phase = PH_HDR;
                     end else begin
                        nxt.phase = PH_BODY;
                     end
                  end
               end
            end else if (func == FUNC_DIFF_END) begin
               if (cur.header_count == 3'd0) begin
                  nxt.phase = PH_FINAL;
               end else begin
                  nxt.sticky_status = ST_DIFF_SHORT;
                  nxt.phase         = PH_STOP;
               end
            end
         end

         PH_FINAL: begin
            if (func == FUNC_SRC) begin
               nxt.sticky_status = ST_EXTRA_SRC;
               nxt.phase         = PH_STOP;
            end else if (func == FUNC_SRC_END) begin
               nxt.sticky_status = ST_DONE;
               nxt.phase         = PH_STOP;
            end
         end

         PH_PLOAD: begin
            if (func == FUNC_DIFF) begin
               nxt.fill_pattern  = cur.fill_pattern |
                  ({24'd0, data_byte} << {cur.pattern_index, 3'b000});
               nxt.pattern_index = pi_inc;
               if (pi_inc == 2'd0) begin
                  if (cur.remaining_length == 32'd0) begin
                     nxt.phase        = PH_HDR;
                     nxt.header_count = 3'd0;
                  end else begin
                     nxt.phase = (cur.record_kind == KIND_FILL) ? PH_FILL : PH_BODY;
                  end
               end
            end else if (func == FUNC_DIFF_END) begin
               nxt.sticky_status = ST_DIFF_SHORT;
               nxt.phase         = PH_STOP;
            end
         end

         PH_FILL: begin
            // The item's code and byte are ignored; it only clocks out one pattern byte.
            res.out_valid        = 1'b1;
            res.out_byte         = pat_byte;
            nxt.pattern_index    = pi_inc;
            nxt.remaining_length = rl_dec;
            if (rl_dec == 32'd0) begin
               nxt.phase        = PH_HDR;
               nxt.header_count = 3'd0;
            end
         end

         PH_BODY: begin
            if (need == WANT_SRC && func == FUNC_SRC_END) begin
               nxt.sticky_status = ST_SRC_SHORT;
               nxt.phase         = PH_STOP;
            end else if (need == WANT_DIFF && func == FUNC_DIFF_END) begin
               nxt.sticky_status = ST_DIFF_SHORT;
               nxt.phase         = PH_STOP;
            end else if (body_take) begin
               case (cur.record_kind)
                  KIND_COPY, KIND_INSERT: begin
                     res.out_valid        = 1'b1;
                     res.out_byte         = data_byte;
                     nxt.remaining_length = rl_dec;
                     if (rl_dec == 32'd0) begin
                        nxt.phase        = PH_HDR;
                        nxt.header_count = 3'd0;
                     end
                  end
                  KIND_XOR, KIND_VERIFY: begin
                     if (!cur.have_source) begin
                        nxt.held_source = data_byte;
                        nxt.have_source = 1'b1;
                     end else begin
                        nxt.have_source = 1'b0;
                        if (cur.record_kind == KIND_VERIFY &&
                            cur.held_source != data_byte) begin
                           nxt.sticky_status = ST_MISMATCH;
                           nxt.phase         = PH_STOP;
                        end else begin
                           if (cur.record_kind == KIND_XOR) begin
                              res.out_valid = 1'b1;
                              res.out_byte  = cur.held_source ^ data_byte;
                           end
                           nxt.remaining_length = rl_dec;
                           if (rl_dec == 32'd0) begin
                              nxt.phase        = PH_HDR;
                              nxt.header_count = 3'd0;
                           end
                        end
                     end
                  end
                  default: begin
                     if (data_byte != pat_byte) begin
                        nxt.sticky_status = ST_MISMATCH;
                        nxt.phase         = PH_STOP;
                     end else begin
                        nxt.pattern_index    = pi_inc;
                        nxt.remaining_length = rl_dec;
                        if (rl_dec == 32'd0) begin
                           nxt.phase        = PH_HDR;
                           nxt.header_count = 3'd0;
                        end
                     end
                  end
               endcase
            end
         end

         default: begin
            // Finished or failed: everything is ignored.
         end
      endcase

      res.want_stream = wanted(nxt);
      res.status      = nxt.sticky_status;
   end

endmodule

>>> src/binary_diff_patch_applier.sv
// ---------------------------------------------------------------------------
// binary_diff_patch_applier
// Applies a record-structured binary diff stream to a source byte stream and
// returns one result per input item: an optional destination byte, the stream
// wanted next and the running status.
// ---------------------------------------------------------------------------
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   req     | req_valid/ready, req_func, req_data_byte | in
//   rsp     | rsp_valid/ready, rsp_out_valid, rsp_out_byte,
//           | rsp_want_stream, rsp_status            | out
//   csr     | csr_write_enable, csr_write_data       | in
//
// Each accepted transfer is processed in the cycle it is accepted: the parser
// state advances at that edge and the result lands in the output register;
// a new item is taken every cycle while the output register is not stalled.
// The output register is the only stage; req_ready is high whenever it is
// empty or being drained, so a stall on rsp holds back req by one item only.
// Synchronous reset returns the parser to "expecting header", clears reverse
// mode and empties the output register.
// ---------------------------------------------------------------------------
module binary_diff_patch_applier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_want_stream,
   output logic [2:0] rsp_status,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import bdpa_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic       reverse_ff;
   logic       req_take;

   // The output register can take a new result when it is empty or when its
   // current result is leaving in this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   bdpa_step u_step (
      .cur          (state_ff),
      .reverse_mode (reverse_ff),
      .func         (req_func),
      .data_byte    (req_data_byte),
      .nxt          (state_in),
      .res          (result_in)
   );

   // Parser state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= STATE_RESET;
         reverse_ff <= 1'b0;
      end else begin
         if (req_take)
            state_ff <= state_in;
         if (csr_write_enable)
            reverse_ff <= csr_write_data;
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload; it only loads on an accepted transfer.
   always_ff @(posedge clock) begin
      if (req_take)
         result_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_valid   = result_ff.out_valid;
   assign rsp_out_byte    = result_ff.out_byte;
   assign rsp_want_stream = result_ff.want_stream;
   assign rsp_status      = result_ff.status;

endmodule
